[src/srgbwb_pkg.sv]
`default_nettype none

package srgbwb_pkg;

    // pixel and register code width
    localparam int CODE_W = 8;
    localparam int CODE_COUNT = 256;
    localparam int NUM_CHANNELS = 3;
    localparam int SEARCH_STAGES = 8;

    // gains carry a fixed 16-bit fraction
    localparam int GAIN_FRAC_BITS = 16;

    // native precision of the sRGB curve table
    localparam int CURVE_FRAC_BITS = 24;

    // patch register indexes
    localparam logic [2:0] REG_MEASURED_RED   = 3'd0;
    localparam logic [2:0] REG_MEASURED_GREEN = 3'd1;
    localparam logic [2:0] REG_MEASURED_BLUE  = 3'd2;
    localparam logic [2:0] REG_TARGET_RED     = 3'd3;
    localparam logic [2:0] REG_TARGET_GREEN   = 3'd4;
    localparam logic [2:0] REG_TARGET_BLUE    = 3'd5;
    localparam int NUM_REGS = 6;

    // channel numbering of the gain row
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // gain update sequencer
    typedef enum logic [1:0] {
        GS_IDLE,
        GS_SETUP,
        GS_DIV,
        GS_WRITE
    } gain_state_t;

    // Q0.31 product with round to nearest
    function automatic longint unsigned mul31(input longint unsigned a,
                                              input longint unsigned b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // sRGB decode of k/510 in Q0.24, evaluated at elaboration only
    function automatic longint unsigned curve24(input int unsigned k);
        longint unsigned num;
        longint unsigned x;
        longint unsigned w;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned r2;
        longint unsigned r4;
        longint unsigned p5;
        longint unsigned v;
        begin
            if (k <= 20)
            begin
                v = (64'(k) * 64'd100 * 64'd16777216 + 64'd329460) / 64'd658920;
            end
            else
            begin
                num = 64'd1000 * 64'(k) + 64'd28050;
                x = ((num << 31) + 64'd269025) / 64'd538050;
                w = mul31(x, x);
                lo = 64'd0;
                hi = 64'd1 << 31;
                // fifth root of w by bisection
                for (int i = 0; i < 34; i++)
                begin
                    if (lo < hi)
                    begin
                        mid = (lo + hi + 64'd1) >> 1;
                        r2 = mul31(mid, mid);
                        r4 = mul31(r2, r2);
                        p5 = mul31(r4, mid);
                        if (p5 <= w)
                            lo = mid;
                        else
                            hi = mid - 64'd1;
                    end
                end
                v = (mul31(w, lo) + 64'd64) >> 7;
            end
            return v;
        end
    endfunction

    // curve point rounded to the linear fraction width
    function automatic logic [31:0] curve_lin(input int unsigned idx,
                                              input int unsigned frac_bits);
        longint unsigned v;
        int unsigned s;
        begin
            v = curve24(idx);
            if (frac_bits >= CURVE_FRAC_BITS)
                return v[31:0];
            s = CURVE_FRAC_BITS - frac_bits;
            v = (v + (64'd1 << (s - 1))) >> s;
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

[src/srgb_single_patch_white_balance_unit.sv]
// single-patch white balance for 8-bit sRGB pixels
//
// s_* stream: one pixel word, blue in the low byte, then green, then red.
// m_* stream: the corrected pixel word in the same byte order.
// apb port: six 8-bit patch registers at byte addresses 0,4,..,20
// (measured red/green/blue, target red/green/blue), read back on prdata.
//
// each channel is decoded to linear light, scaled by its gain, clamped to
// 1.0 and re-encoded to the nearest sRGB code. one word is taken per clock
// while s_tready is high; a word is registered after decode, multiply,
// clamp and each of eight steps of a binary search over the encode
// thresholds. the pipeline stages move independently, so bubbles are
// squeezed out and new words are taken while a finished word waits on a
// low m_tready; the pipeline fills and then holds until m_tready returns.
//
// gains sit in a two-bank memory. after reset and after every register write
// a sequencer recomputes the three gains with a bit-serial divider into the
// idle bank, then swaps banks; a channel with a zero measured or target
// value skips the divider. s_tready is low meanwhile; reset loads all patch
// registers with 255 (unity).
`default_nettype none

module srgb_single_patch_white_balance_unit #(
    parameter int LINEAR_FRACTION_BITS = 16,
    parameter int GAIN_INTEGER_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // pixel in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pixel_blue, pixel_green, pixel_red
    // pixel out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // mapped_blue, mapped_green, mapped_red
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CW = srgbwb_pkg::CODE_W;
    localparam int NCH = srgbwb_pkg::NUM_CHANNELS;
    localparam int GFB = srgbwb_pkg::GAIN_FRAC_BITS;
    localparam int NSRCH = srgbwb_pkg::SEARCH_STAGES;
    localparam int LIN_W = LINEAR_FRACTION_BITS + 1;
    localparam int GAIN_W = GAIN_INTEGER_BITS + GFB;
    localparam int ROW_W = NCH * GAIN_W;
    localparam int PROD_W = LIN_W + GAIN_W;
    localparam int PR_W = PROD_W + 1 - GFB;
    localparam int NUM_W = LINEAR_FRACTION_BITS + 18;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int CMP_W = (NUM_W > GAIN_W) ? NUM_W : GAIN_W;
    localparam int NSTAGE = 3 + NSRCH;
    localparam int GAIN_BANKS = 2;
    localparam int BANK_W = $clog2(GAIN_BANKS);
    localparam logic [LIN_W-1:0] LIN_ONE = {1'b1, {LINEAR_FRACTION_BITS{1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (GFB - 1);

    // ------------------------------------------------------------------
    // curve tables
    // ------------------------------------------------------------------
    logic [LIN_W-1:0] dec_lut [srgbwb_pkg::CODE_COUNT];
    logic [LIN_W-1:0] enc_lut [srgbwb_pkg::CODE_COUNT];

    for (genvar gi = 0; gi < srgbwb_pkg::CODE_COUNT; gi++)
    begin : g_lut
        // code c decodes to curve point 2c
        assign dec_lut[gi] = LIN_W'(srgbwb_pkg::curve_lin(2 * gi, LINEAR_FRACTION_BITS));
        // threshold between codes j and j+1 is curve point 2j+1
        if (gi < srgbwb_pkg::CODE_COUNT - 1)
        begin : g_thr
            assign enc_lut[gi] =
                LIN_W'(srgbwb_pkg::curve_lin(2 * gi + 1, LINEAR_FRACTION_BITS));
        end
        else
        begin : g_top
            assign enc_lut[gi] = {LIN_W{1'b1}};
        end
    end

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic [CW-1:0] patch_reg [srgbwb_pkg::NUM_REGS];
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr = psel && penable && pwrite && pready;

    // patch registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < srgbwb_pkg::NUM_REGS; i++)
            begin
                patch_reg[i] <= {CW{1'b1}};
            end
        end
        else if (cfg_wr && (reg_idx <= srgbwb_pkg::REG_TARGET_BLUE))
        begin
            patch_reg[reg_idx] <= pwdata[CW-1:0];
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            srgbwb_pkg::REG_MEASURED_RED:
                prdata = 32'(patch_reg[srgbwb_pkg::REG_MEASURED_RED]);
            srgbwb_pkg::REG_MEASURED_GREEN:
                prdata = 32'(patch_reg[srgbwb_pkg::REG_MEASURED_GREEN]);
            srgbwb_pkg::REG_MEASURED_BLUE:
                prdata = 32'(patch_reg[srgbwb_pkg::REG_MEASURED_BLUE]);
            srgbwb_pkg::REG_TARGET_RED:
                prdata = 32'(patch_reg[srgbwb_pkg::REG_TARGET_RED]);
            srgbwb_pkg::REG_TARGET_GREEN:
                prdata = 32'(patch_reg[srgbwb_pkg::REG_TARGET_GREEN]);
            srgbwb_pkg::REG_TARGET_BLUE:
                prdata = 32'(patch_reg[srgbwb_pkg::REG_TARGET_BLUE]);
            default:
                prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // gain memory
    // ------------------------------------------------------------------
    logic              gain_we;
    logic [BANK_W-1:0] act_reg;
    logic [BANK_W-1:0] back_bank;
    logic [ROW_W-1:0]  gain_wrow;
    logic [ROW_W-1:0]  live_row;
    logic [ROW_W-1:0]  back_row;

    assign back_bank = ~act_reg;

    srgbwb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (GAIN_BANKS)
    ) u_gain_ram (
        .clk     (clk),
        .we      (gain_we),
        .waddr   (back_bank),
        .wdata   (gain_wrow),
        .raddr_a (act_reg),
        .rdata_a (live_row),
        .raddr_b (back_bank),
        .rdata_b (back_row)
    );

    // ------------------------------------------------------------------
    // gain sequencer
    // ------------------------------------------------------------------
    srgbwb_pkg::gain_state_t gain_state_reg;
    srgbwb_pkg::gain_state_t gain_state_next;
    logic [1:0]        ch_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [LIN_W-1:0]  rem_reg;
    logic [LIN_W-1:0]  divisor_reg;
    logic              sat_reg;
    logic [CW-1:0]     meas_code;
    logic [CW-1:0]     targ_code;
    logic [LIN_W-1:0]  meas_lin;
    logic [LIN_W-1:0]  targ_lin;
    logic              special;
    logic              busy;
    logic              bank_swap;
    logic [LIN_W:0]    rem_sh;
    logic              rem_ge;
    logic [GAIN_W-1:0] gain_val;

    // patch codes of the channel being worked on
    always_comb
    begin
        case (ch_reg)
            srgbwb_pkg::CH_RED:
            begin
                meas_code = patch_reg[srgbwb_pkg::REG_MEASURED_RED];
                targ_code = patch_reg[srgbwb_pkg::REG_TARGET_RED];
            end
            srgbwb_pkg::CH_GREEN:
            begin
                meas_code = patch_reg[srgbwb_pkg::REG_MEASURED_GREEN];
                targ_code = patch_reg[srgbwb_pkg::REG_TARGET_GREEN];
            end
            default:
            begin
                meas_code = patch_reg[srgbwb_pkg::REG_MEASURED_BLUE];
                targ_code = patch_reg[srgbwb_pkg::REG_TARGET_BLUE];
            end
        endcase
    end

    assign meas_lin = dec_lut[meas_code];
    assign targ_lin = dec_lut[targ_code];
    assign special = (targ_lin == '0) || (meas_lin == '0);

    // next state
    always_comb
    begin
        gain_state_next = gain_state_reg;
        case (gain_state_reg)
            srgbwb_pkg::GS_IDLE:
                gain_state_next = srgbwb_pkg::GS_IDLE;
            srgbwb_pkg::GS_SETUP:
                gain_state_next = special ? srgbwb_pkg::GS_WRITE : srgbwb_pkg::GS_DIV;
            srgbwb_pkg::GS_DIV:
                if (div_cnt_reg == CNT_W'(1))
                    gain_state_next = srgbwb_pkg::GS_WRITE;
            srgbwb_pkg::GS_WRITE:
                gain_state_next = (ch_reg == srgbwb_pkg::CH_BLUE) ?
                                  srgbwb_pkg::GS_IDLE : srgbwb_pkg::GS_SETUP;
            default:
                gain_state_next = srgbwb_pkg::GS_IDLE;
        endcase
        if (cfg_wr)
            gain_state_next = srgbwb_pkg::GS_SETUP;
    end

    // sequencer outputs
    always_comb
    begin
        gain_we = 1'b0;
        busy = 1'b1;
        case (gain_state_reg)
            srgbwb_pkg::GS_IDLE:
                busy = 1'b0;
            srgbwb_pkg::GS_WRITE:
                gain_we = 1'b1;
            default:
                gain_we = 1'b0;
        endcase
        bank_swap = gain_we && (ch_reg == srgbwb_pkg::CH_BLUE);
    end

    // one restoring division step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= (LIN_W + 1)'(divisor_reg);

    // saturate the quotient into the gain format
    always_comb
    begin
        if (sat_reg || (CMP_W'(num_reg) > CMP_W'(GAIN_MAX)))
            gain_val = GAIN_MAX;
        else
            gain_val = GAIN_W'(num_reg);
        gain_wrow = back_row;
        gain_wrow[ch_reg * GAIN_W +: GAIN_W] = gain_val;
    end

    // sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_state_reg <= srgbwb_pkg::GS_SETUP;
            ch_reg <= srgbwb_pkg::CH_RED;
            div_cnt_reg <= '0;
            act_reg <= '0;
        end
        else
        begin
            gain_state_reg <= gain_state_next;
            if (bank_swap)
                act_reg <= back_bank;
            if (cfg_wr)
                ch_reg <= srgbwb_pkg::CH_RED;
            else if (gain_we)
                ch_reg <= (ch_reg == srgbwb_pkg::CH_BLUE) ? srgbwb_pkg::CH_RED
                                                          : ch_reg + 2'd1;
            if (gain_state_reg == srgbwb_pkg::GS_SETUP)
                div_cnt_reg <= CNT_W'(NUM_W);
            else if (gain_state_reg == srgbwb_pkg::GS_DIV)
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (gain_state_reg == srgbwb_pkg::GS_SETUP)
        begin
            rem_reg <= '0;
            divisor_reg <= meas_lin;
            sat_reg <= (targ_lin != '0) && (meas_lin == '0);
            if (targ_lin == '0)
                num_reg <= '0;
            else
                num_reg <= (NUM_W'(targ_lin) << GFB) + NUM_W'(meas_lin >> 1);
        end
        else if (gain_state_reg == srgbwb_pkg::GS_DIV)
        begin
            rem_reg <= rem_ge ? LIN_W'(rem_sh - (LIN_W + 1)'(divisor_reg))
                              : rem_sh[LIN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], rem_ge};
        end
    end

    // ------------------------------------------------------------------
    // pixel pipeline
    // ------------------------------------------------------------------
    logic              vld_reg [NSTAGE];
    logic              en [NSTAGE];
    logic [LIN_W-1:0]  lin_reg [NCH];
    logic [PR_W-1:0]   prod_reg [NCH];
    logic [LIN_W-1:0]  y_reg [NCH];
    logic [LIN_W-1:0]  sy_reg [NSRCH][NCH];
    logic [CW-1:0]     spos_reg [NSRCH][NCH];
    logic [GAIN_W-1:0] lane_gain [NCH];
    logic [PROD_W-1:0] mul [NCH];
    logic [PROD_W:0]   mul_rnd [NCH];
    logic [LIN_W-1:0]  sin_y [NSRCH][NCH];
    logic [CW-1:0]     sin_pos [NSRCH][NCH];
    logic [CW-1:0]     cand [NSRCH][NCH];
    logic [CW-1:0]     spos_next [NSRCH][NCH];

    // stage advance, from the output back
    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i + 1];
        end
    end

    assign s_tready = en[0] && !busy;

    // lane 0 is blue, so it takes the last gain of the row
    always_comb
    begin
        for (int l = 0; l < NCH; l++)
        begin
            lane_gain[l] = live_row[(NCH - 1 - l) * GAIN_W +: GAIN_W];
            mul[l] = PROD_W'(lin_reg[l]) * PROD_W'(lane_gain[l]);
            mul_rnd[l] = (PROD_W + 1)'(mul[l]) + ROUND_HALF;
        end
    end

    // encode search, one code bit per stage
    always_comb
    begin
        for (int l = 0; l < NCH; l++)
        begin
            sin_y[0][l] = y_reg[l];
            sin_pos[0][l] = '0;
            for (int s = 1; s < NSRCH; s++)
            begin
                sin_y[s][l] = sy_reg[s - 1][l];
                sin_pos[s][l] = spos_reg[s - 1][l];
            end
            for (int s = 0; s < NSRCH; s++)
            begin
                cand[s][l] = sin_pos[s][l] | (CW'(1) << (NSRCH - 1 - s));
                if (enc_lut[cand[s][l] - CW'(1)] <= sin_y[s][l])
                    spos_next[s][l] = cand[s][l];
                else
                    spos_next[s][l] = sin_pos[s][l];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= s_tvalid && s_tready;
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i - 1];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NCH; l++)
        begin
            if (en[0])
                lin_reg[l] <= dec_lut[s_tdata[l * CW +: CW]];
            if (en[1])
                prod_reg[l] <= mul_rnd[l][PROD_W:GFB];
            if (en[2])
                y_reg[l] <= (prod_reg[l] > PR_W'(LIN_ONE)) ? LIN_ONE
                                                           : prod_reg[l][LIN_W-1:0];
            for (int s = 0; s < NSRCH; s++)
            begin
                if (en[3 + s])
                begin
                    sy_reg[s][l] <= sin_y[s][l];
                    spos_reg[s][l] <= spos_next[s][l];
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata = {spos_reg[NSRCH-1][2], spos_reg[NSRCH-1][1], spos_reg[NSRCH-1][0]};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_pixel_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (gain_state_reg == srgbwb_pkg::GS_IDLE))
        else $error("pixel port ready during gain update");

    a_write_restarts_gains: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (gain_state_reg == srgbwb_pkg::GS_SETUP))
        else $error("register write did not restart gain update");

    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (gain_state_reg == srgbwb_pkg::GS_DIV) |-> (div_cnt_reg != '0))
        else $error("divider ran past its last step");

    a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> ((y_reg[0] <= LIN_ONE) && (y_reg[1] <= LIN_ONE)
                        && (y_reg[2] <= LIN_ONE)))
        else $error("clamped linear value above one");

endmodule

`default_nettype wire

[src/srgbwb_ram.sv]
`default_nettype none

module srgbwb_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire
